// ===== rtl/dpm_pkg.sv =====
`default_nettype none
package dpm_pkg;

   localparam int T_W    = 15;   // temperature, hundredths degC, signed
   localparam int H_W    = 14;   // humidity, hundredths percent
   localparam int E_W    = 4;    // exponent of the top set humidity bit
   localparam int LNK_W  = 21;   // ln(rh/100) in q16, signed
   localparam int LO_W   = 16;
   localparam int DF_W   = 12;
   localparam int FR_W   = 12;
   localparam int LNP_W  = 20;
   localparam int N1_W   = 42;   // rounded temperature-term numerator magnitude
   localparam int D1_W   = 22;   // temperature-term divisor
   localparam int Q1_W   = 22;   // temperature-term quotient magnitude
   localparam int K_W    = 23;   // magnus k in q16, signed
   localparam int N2_W   = 43;
   localparam int D2_W   = 29;
   localparam int Q2_W   = 16;
   localparam int DEW_W  = 15;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam logic [LNP_W-1:0]   LN2_Q16     = 20'd45426;
   localparam logic signed [LNK_W-1:0] LN10000_Q16 = 21'sd603609;
   localparam logic signed [31:0] D2_BASE     = 32'sd115474432;  // 1762*65536
   localparam logic [21:0]        DEW_SCALE   = 22'd2431200;
   localparam logic signed [DEW_W+1:0] DEW_MIN = -17'sd12000;
   localparam logic signed [DEW_W+1:0] DEW_MAX = 17'sd12500;

   // ln(1+i/16) in q16
   localparam logic [LO_W-1:0] LN_TAB [17] = '{
      16'd0,     16'd3973,  16'd7719,  16'd11262, 16'd14624, 16'd17821,
      16'd20870, 16'd23783, 16'd26573, 16'd29248, 16'd31818, 16'd34292,
      16'd36675, 16'd38975, 16'd41196, 16'd43345, 16'd45426
   };

   typedef struct packed {
      logic signed [T_W-1:0]   temperature;
      logic signed [LNK_W-1:0] lnk;
      logic                    invalid;
   } dpm_entry_type;

endpackage
`default_nettype wire

// ===== rtl/dpm_front.sv =====
`default_nettype none
module dpm_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [dpm_pkg::T_W-1:0] req_temperature,
   input  wire logic [dpm_pkg::H_W-1:0]      req_humidity,
   output logic                              push,
   output dpm_pkg::dpm_entry_type            push_entry,
   input  wire logic                         full
);
   import dpm_pkg::*;

   logic                  f1_valid_ff, f1_valid_in;
   logic signed [T_W-1:0] f1_t_ff;
   logic [H_W-1:0]        f1_h_ff;

   logic                  f2_valid_ff, f2_valid_in;
   logic signed [T_W-1:0] f2_t_ff;
   logic                  f2_inv_ff, f2_inv_in;
   logic [E_W-1:0]        f2_e_ff, f2_e_in;
   logic [LO_W-1:0]       f2_lo_ff, f2_lo_in;
   logic [DF_W-1:0]       f2_df_ff, f2_df_in;
   logic [FR_W-1:0]       f2_fr_ff, f2_fr_in;

   logic                  adv;
   logic [29:0]           norm;
   logic [3:0]            idx;
   logic [4:0]            idx_hi;
   logic [24:0]           prod;
   logic [LNP_W-1:0]      ln_pos;

   assign adv       = !f2_valid_ff || !full;
   assign req_stall = !adv;
   assign push      = f2_valid_ff && !full;

   assign f1_valid_in = req_valid;
   assign f2_valid_in = f1_valid_ff;

   // normalize humidity and look up the log segment
   always_comb begin
      f2_e_in = '0;
      for (int i = 0; i < H_W; i++) begin
         if (f1_h_ff[i]) f2_e_in = E_W'(i);
      end
      norm      = {16'b0, f1_h_ff} << (5'd16 - {1'b0, f2_e_in});
      idx       = norm[15:12];
      idx_hi    = {1'b0, idx} + 5'd1;
      f2_fr_in  = norm[11:0];
      f2_lo_in  = LN_TAB[{1'b0, idx}];
      f2_df_in  = DF_W'(LN_TAB[idx_hi] - LN_TAB[{1'b0, idx}]);
      f2_inv_in = (f1_h_ff == '0);
   end

   // interpolate and remove ln(10000)
   always_comb begin
      prod   = 25'(f2_df_ff) * 25'(f2_fr_ff) + 25'd2048;
      ln_pos = LNP_W'(f2_e_ff * LN2_Q16) + LNP_W'(f2_lo_ff) + LNP_W'(prod[24:12]);
      push_entry.temperature = f2_t_ff;
      push_entry.lnk         = $signed({1'b0, ln_pos}) - LN10000_Q16;
      push_entry.invalid     = f2_inv_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (adv) begin
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_t_ff   <= req_temperature;
         f1_h_ff   <= req_humidity;
         f2_t_ff   <= f1_t_ff;
         f2_inv_ff <= f2_inv_in;
         f2_e_ff   <= f2_e_in;
         f2_lo_ff  <= f2_lo_in;
         f2_df_ff  <= f2_df_in;
         f2_fr_ff  <= f2_fr_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/dpm_fifo.sv =====
`default_nettype none
module dpm_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire dpm_pkg::dpm_entry_type push_entry,
   output logic                        full,
   input  wire logic                   pop,
   output dpm_pkg::dpm_entry_type      pop_entry,
   output logic                        empty
);
   import dpm_pkg::*;

   dpm_entry_type        mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [FIFO_AW:0]     cnt_ff, cnt_in;

   assign full      = (cnt_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign empty     = (cnt_ff == '0);
   assign pop_entry = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_entry;
   end

endmodule
`default_nettype wire

// ===== rtl/dpm_back.sv =====
`default_nettype none
module dpm_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              empty,
   input  wire dpm_pkg::dpm_entry_type            pop_entry,
   output logic                                   pop,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [dpm_pkg::DEW_W-1:0]       rsp_dew_point,
   output logic                                   rsp_invalid
);
   import dpm_pkg::*;

   logic adv;

   // first division: temperature term
   logic                    v1_ff   [Q1_W+1];
   logic [N1_W-1:0]         r1_ff   [Q1_W+1];
   logic [N1_W-1:0]         r1_in   [Q1_W+1];
   logic [Q1_W-1:0]         q1_ff   [Q1_W+1];
   logic [Q1_W-1:0]         q1_in   [Q1_W+1];
   logic [D1_W-1:0]         d1_ff   [Q1_W+1];
   logic                    n1_ff   [Q1_W+1];
   logic                    i1_ff   [Q1_W+1];
   logic signed [LNK_W-1:0] l1_ff   [Q1_W+1];
   logic [N1_W:0]           sh1     [Q1_W];

   // second division: dew point
   logic                    v2_ff   [Q2_W+1];
   logic [N2_W-1:0]         r2_ff   [Q2_W+1];
   logic [N2_W-1:0]         r2_in   [Q2_W+1];
   logic [Q2_W-1:0]         q2_ff   [Q2_W+1];
   logic [Q2_W-1:0]         q2_in   [Q2_W+1];
   logic [D2_W-1:0]         d2_ff   [Q2_W+1];
   logic                    n2_ff   [Q2_W+1];
   logic                    i2_ff   [Q2_W+1];
   logic [N2_W:0]           sh2     [Q2_W];

   logic                    kv_ff, ki_ff;
   logic signed [K_W-1:0]   k_ff, k_in;

   logic signed [25:0]      p1;
   logic [24:0]             p1_mag;
   logic [15:0]             s1;
   logic [N1_W-1:0]         r1_start;
   logic [D1_W-1:0]         d1_start;

   logic [K_W-2:0]          k_mag;
   logic [N2_W:0]           n2;
   logic signed [31:0]      d2s;
   logic [N2_W-1:0]         r2_start;

   logic signed [DEW_W+1:0] dew;
   logic signed [DEW_W-1:0] dew_in;
   logic                    out_v_ff;

   assign adv       = !out_v_ff || !rsp_stall;
   assign pop       = adv && !empty;
   assign rsp_valid = out_v_ff;

   always_comb begin
      p1       = 26'(pop_entry.temperature) * 26'sd1762;
      p1_mag   = p1[25] ? 25'(-p1) : p1[24:0];
      s1       = 16'(17'($signed(pop_entry.temperature)) + 17'sd24312);
      d1_start = D1_W'(s1 * 7'd100);
      r1_start = {p1_mag, 16'b0} + N1_W'(s1 * 6'd50);
   end

   always_comb begin
      r1_in[0] = '0;
      q1_in[0] = '0;
      for (int j = 0; j < Q1_W; j++) begin
         sh1[j] = (N1_W+1)'(d1_ff[j]) << (Q1_W-1-j);
         if ({1'b0, r1_ff[j]} >= sh1[j]) begin
            r1_in[j+1] = r1_ff[j] - sh1[j][N1_W-1:0];
            q1_in[j+1] = q1_ff[j] | (Q1_W'(1) << (Q1_W-1-j));
         end else begin
            r1_in[j+1] = r1_ff[j];
            q1_in[j+1] = q1_ff[j];
         end
      end
   end

   always_comb begin
      k_in = K_W'(l1_ff[Q1_W]) +
             (n1_ff[Q1_W] ? -$signed({1'b0, q1_ff[Q1_W]}) : $signed({1'b0, q1_ff[Q1_W]}));
      k_mag    = k_ff[K_W-1] ? (K_W-1)'(-k_ff) : k_ff[K_W-2:0];
      n2       = (N2_W+1)'(k_mag * DEW_SCALE);
      d2s      = D2_BASE - 32'sd100 * 32'(k_ff);
      r2_start = n2[N2_W-1:0] + N2_W'(d2s[D2_W-1:1]);
   end

   always_comb begin
      r2_in[0] = '0;
      q2_in[0] = '0;
      for (int j = 0; j < Q2_W; j++) begin
         sh2[j] = (N2_W+1)'(d2_ff[j]) << (Q2_W-1-j);
         if ({1'b0, r2_ff[j]} >= sh2[j]) begin
            r2_in[j+1] = r2_ff[j] - sh2[j][N2_W-1:0];
            q2_in[j+1] = q2_ff[j] | (Q2_W'(1) << (Q2_W-1-j));
         end else begin
            r2_in[j+1] = r2_ff[j];
            q2_in[j+1] = q2_ff[j];
         end
      end
   end

   // sign, saturate, invalid forces zero
   always_comb begin
      dew = n2_ff[Q2_W] ? -$signed({1'b0, q2_ff[Q2_W]}) : $signed({1'b0, q2_ff[Q2_W]});
      if (i2_ff[Q2_W])        dew_in = '0;
      else if (dew < DEW_MIN) dew_in = DEW_W'(DEW_MIN);
      else if (dew > DEW_MAX) dew_in = DEW_W'(DEW_MAX);
      else                    dew_in = dew[DEW_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= Q1_W; j++) v1_ff[j] <= 1'b0;
         for (int j = 0; j <= Q2_W; j++) v2_ff[j] <= 1'b0;
         kv_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         v1_ff[0] <= !empty;
         for (int j = 1; j <= Q1_W; j++) v1_ff[j] <= v1_ff[j-1];
         kv_ff    <= v1_ff[Q1_W];
         v2_ff[0] <= kv_ff;
         for (int j = 1; j <= Q2_W; j++) v2_ff[j] <= v2_ff[j-1];
         out_v_ff <= v2_ff[Q2_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r1_ff[0] <= r1_start;
         q1_ff[0] <= '0;
         d1_ff[0] <= d1_start;
         n1_ff[0] <= pop_entry.temperature[T_W-1];
         i1_ff[0] <= pop_entry.invalid;
         l1_ff[0] <= pop_entry.lnk;
         for (int j = 1; j <= Q1_W; j++) begin
            r1_ff[j] <= r1_in[j];
            q1_ff[j] <= q1_in[j];
            d1_ff[j] <= d1_ff[j-1];
            n1_ff[j] <= n1_ff[j-1];
            i1_ff[j] <= i1_ff[j-1];
            l1_ff[j] <= l1_ff[j-1];
         end
         k_ff  <= k_in;
         ki_ff <= i1_ff[Q1_W];
         r2_ff[0] <= r2_start;
         q2_ff[0] <= '0;
         d2_ff[0] <= d2s[D2_W-1:0];
         n2_ff[0] <= k_ff[K_W-1];
         i2_ff[0] <= ki_ff;
         for (int j = 1; j <= Q2_W; j++) begin
            r2_ff[j] <= r2_in[j];
            q2_ff[j] <= q2_in[j];
            d2_ff[j] <= d2_ff[j-1];
            n2_ff[j] <= n2_ff[j-1];
            i2_ff[j] <= i2_ff[j-1];
         end
         rsp_dew_point <= dew_in;
         rsp_invalid   <= i2_ff[Q2_W];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/dew_point_magnus.sv =====
`default_nettype none
// Dew point by the Magnus formula (17.62, 243.12 degC). Each request beat carries a
// temperature and a relative humidity in hundredths; each response beat carries the
// dew point in hundredths, saturated to -120.00..125.00 degC, and an invalid flag
// that is set, with a dew point of zero, when humidity is zero. One beat is taken
// every cycle while req_stall is low: there is no state between samples. A request
// passes through the front (normalize and table lookup of the log), through the
// four-entry queue, and through the back end, whose depth is set mostly by the two
// radix-2 divider pipelines (22 stages for the temperature term, 16 for the final
// quotient). Response stall stops only the back end; the queue lets the front keep
// taking beats until it fills.
module dew_point_magnus (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [dpm_pkg::T_W-1:0]    req_temperature,
   input  wire logic [dpm_pkg::H_W-1:0]           req_humidity,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [dpm_pkg::DEW_W-1:0]       rsp_dew_point,
   output logic                                   rsp_invalid
);
   import dpm_pkg::*;

   // front to queue
   logic          push, full;
   dpm_entry_type push_entry;
   // queue to back
   logic          pop, empty;
   dpm_entry_type pop_entry;

   // front: accept, flag zero humidity, build ln(rh/100)
   dpm_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_temperature (req_temperature),
      .req_humidity    (req_humidity),
      .push            (push),
      .push_entry      (push_entry),
      .full            (full)
   );

   // decouples the two halves
   dpm_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .empty      (empty)
   );

   // back: temperature term, k, final quotient, saturation
   dpm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .empty         (empty),
      .pop_entry     (pop_entry),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_dew_point (rsp_dew_point),
      .rsp_invalid   (rsp_invalid)
   );

endmodule
`default_nettype wire
